[rtl/ssa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared sizes, codes and types of the slab slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

    // Geometry
    localparam int SLOTS      = 64;
    localparam int SLABS      = 16;
    localparam int SLOT_IW    = $clog2(SLOTS);        // slot index bits
    localparam int SLAB_IW    = $clog2(SLABS);        // slab index bits
    localparam int SLOT_W     = $clog2(SLOTS + 1);    // slot index or "none"
    localparam int SLAB_W     = $clog2(SLABS + 1);    // slab index or "none"
    localparam int LINK_DEPTH = SLABS * SLOTS;
    localparam int LINK_AW    = SLAB_IW + SLOT_IW;

    typedef logic [SLOT_W-1:0] slot_id_t;   // also holds counts 0..SLOTS
    typedef logic [SLAB_W-1:0] slab_id_t;

    localparam slot_id_t SLOT_NONE = slot_id_t'(SLOTS);
    localparam slab_id_t SLAB_NONE = slab_id_t'(SLABS);

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_NO_SLAB = 1'b1;

    typedef enum logic [1:0] {
        LIST_NONE,
        LIST_PARTIAL,
        LIST_FULL,
        LIST_EMPTY
    } list_sel_t;

    // Decisions taken in the accept cycle, applied in the result cycle
    typedef struct packed {
        logic               apply;        // update slab record and lists
        logic               create;       // slab is new
        slab_id_t           slab;
        slot_id_t           new_top;
        logic               top_from_ram; // new free top is the link read
        slot_id_t           new_used;
        list_sel_t          from_list;
        list_sel_t          to_list;
        slab_id_t           prv_link;
        slab_id_t           nxt_link;
        logic               res_status;
        logic [SLAB_IW-1:0] res_slab;
        logic [SLOT_IW-1:0] res_slot;
    } op_t;

endpackage

[rtl/ssa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/slab_slot_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_slot_allocator_top
// Slot allocator over 16 slabs of 64 slots with partial/full/empty slab lists.
// ----------------------------------------------------------------------------
// Every command has a transfer at a rising edge with start high and busy
// low, then a result cycle in which done is high for exactly one cycle with
// status, got_slab and got_slot valid. busy is high during that result
// cycle, so a new start is taken at the earliest in the cycle after done.
// The link read issued in the transfer cycle returns in the result cycle,
// where the slab record and list heads are updated. The receiver cannot
// stall the block; results are never held. After reset the block runs a
// loading pass over every slot-link entry that writes every slab's initial
// free chain, slot N links to slot N-1 and slot 0 ends the chain; busy is
// high throughout, so no transfer is taken before the pass ends.
// ----------------------------------------------------------------------------
module slab_slot_allocator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic [ssa_pkg::SLAB_IW-1:0] free_slab,
    input  logic [ssa_pkg::SLOT_IW-1:0] free_slot,
    output logic                        done,
    output logic                        status,
    output logic [ssa_pkg::SLAB_IW-1:0] got_slab,
    output logic [ssa_pkg::SLOT_IW-1:0] got_slot
);

    import ssa_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_RESULT
    } state_t;

    state_t   state_reg, state_next;
    op_t      op_reg, op_next;

    // Loading pass address
    logic [LINK_AW-1:0] init_addr_reg, init_addr_next;

    // List heads and slab count
    slab_id_t partial_top_reg, partial_top_next;
    slab_id_t full_top_reg,    full_top_next;
    slab_id_t empty_top_reg,   empty_top_next;
    slab_id_t slabs_made_reg,  slabs_made_next;

    // Slab records
    slot_id_t free_top_reg [SLABS];
    slot_id_t used_reg     [SLABS];
    slab_id_t prev_reg     [SLABS];
    slab_id_t next_reg     [SLABS];

    // Slot-link RAM
    logic                ram_we;
    logic [LINK_AW-1:0]  ram_waddr;
    slot_id_t            ram_wdata;
    logic [LINK_AW-1:0]  ram_raddr;
    slot_id_t            ram_rdata;

    logic                accept;
    logic                apply;
    logic [SLAB_IW-1:0]  op_idx;
    slab_id_t            head_to;

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_RESULT);
    assign accept = start && !busy;

    assign status   = op_reg.res_status;
    assign got_slab = op_reg.res_slab;
    assign got_slot = op_reg.res_slot;

    ssa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Transfer cycle: pick the slab, read its record once, decide list moves,
    // issue the link read (allocate) or the link write (free).
    // ------------------------------------------------------------------------
    always_comb
    begin
        slab_id_t           sel;
        logic [SLAB_IW-1:0] sidx;
        slot_id_t           r_top;
        slot_id_t           r_used;
        slab_id_t           r_prev;
        slab_id_t           r_next;
        logic               create;
        logic               fail;
        logic               from_empty;
        logic               from_partial;
        logic               free_ok;
        logic [SLOT_IW-1:0] init_slot;

        sel          = {1'b0, free_slab};
        create       = 1'b0;
        fail         = 1'b0;
        from_empty   = 1'b0;
        from_partial = 1'b0;

        if (command == CMD_ALLOC)
        begin
            if (partial_top_reg != SLAB_NONE)
            begin
                sel          = partial_top_reg;
                from_partial = 1'b1;
            end
            else if (empty_top_reg != SLAB_NONE)
            begin
                sel        = empty_top_reg;
                from_empty = 1'b1;
            end
            else if (slabs_made_reg < SLAB_NONE)
            begin
                sel    = slabs_made_reg;
                create = 1'b1;
            end
            else
            begin
                fail = 1'b1;
            end
        end

        sidx    = sel[SLAB_IW-1:0];
        r_top   = free_top_reg[sidx];
        r_used  = used_reg[sidx];
        r_prev  = prev_reg[sidx];
        r_next  = next_reg[sidx];

        // A new slab starts with its whole run of slots on the free chain
        if (create)
        begin
            r_top   = slot_id_t'(SLOTS - 1);
            r_used  = '0;
            r_prev  = SLAB_NONE;
            r_next  = SLAB_NONE;
        end

        op_next            = '0;
        op_next.slab       = sel;
        op_next.create     = create;
        op_next.prv_link   = r_prev;
        op_next.nxt_link   = r_next;
        op_next.new_top    = r_top;
        op_next.from_list  = LIST_NONE;
        op_next.to_list    = LIST_NONE;
        op_next.res_status = STAT_OK;

        ram_we    = 1'b0;
        ram_waddr = {sidx, free_slot};
        ram_wdata = r_top;
        ram_raddr = {sidx, r_top[SLOT_IW-1:0]};

        free_ok = ({1'b0, free_slab} < slabs_made_reg)
                  && ({1'b0, free_slot} < slot_id_t'(SLOTS))
                  && (r_used != '0);

        if (command == CMD_ALLOC)
        begin
            if (fail)
            begin
                op_next.res_status = STAT_NO_SLAB;
            end
            else
            begin
                op_next.apply    = 1'b1;
                op_next.new_used = r_used + slot_id_t'(1);
                op_next.res_slab = sidx;
                // Pop the chain head; an exhausted chain hands out slot 0
                if (r_top < SLOT_NONE)
                begin
                    op_next.res_slot     = r_top[SLOT_IW-1:0];
                    op_next.top_from_ram = 1'b1;
                end

                if (from_empty)
                begin
                    op_next.from_list = LIST_EMPTY;
                    op_next.to_list   = LIST_PARTIAL;
                end
                else if (create)
                begin
                    op_next.to_list = LIST_PARTIAL;
                end

                if (op_next.new_used >= slot_id_t'(SLOTS))
                begin
                    op_next.to_list = LIST_FULL;
                    if (from_partial)
                    begin
                        op_next.from_list = LIST_PARTIAL;
                    end
                end
            end
        end
        else if (free_ok)
        begin
            ram_we           = accept;
            op_next.apply    = 1'b1;
            op_next.new_top  = {1'b0, free_slot};
            op_next.new_used = r_used - slot_id_t'(1);

            if (r_used >= slot_id_t'(SLOTS))
            begin
                op_next.from_list = LIST_FULL;
                op_next.to_list   = LIST_PARTIAL;
            end
            if (op_next.new_used == '0)
            begin
                op_next.to_list = LIST_EMPTY;
                if (op_next.from_list == LIST_NONE)
                begin
                    op_next.from_list = LIST_PARTIAL;
                end
            end
        end

        // Loading pass: slot i links to slot i-1, slot 0 ends the chain
        init_slot = init_addr_reg[SLOT_IW-1:0];
        if (state_reg == S_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = init_addr_reg;
            ram_wdata = (init_slot == '0) ? SLOT_NONE
                                          : ({1'b0, init_slot} - slot_id_t'(1));
        end
    end

    // ------------------------------------------------------------------------
    // Result cycle: apply the record update and the list moves.
    // ------------------------------------------------------------------------
    assign apply  = (state_reg == S_RESULT) && op_reg.apply;
    assign op_idx = op_reg.slab[SLAB_IW-1:0];

    always_comb
    begin
        case (op_reg.to_list)
            LIST_PARTIAL: head_to = partial_top_reg;
            LIST_FULL:    head_to = full_top_reg;
            LIST_EMPTY:   head_to = empty_top_reg;
            default:      head_to = SLAB_NONE;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        init_addr_next   = init_addr_reg;
        partial_top_next = partial_top_reg;
        full_top_next    = full_top_reg;
        empty_top_next   = empty_top_reg;
        slabs_made_next  = slabs_made_reg;

        unique case (state_reg)
            S_INIT:
            begin
                // Advance through every link entry, then go idle
                init_addr_next = init_addr_reg + LINK_AW'(1);
                if (init_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (apply)
        begin
            // Unlink from the old list; advance its head if the slab led it
            if ((op_reg.from_list == LIST_PARTIAL) && (partial_top_reg == op_reg.slab))
            begin
                partial_top_next = op_reg.nxt_link;
            end
            if ((op_reg.from_list == LIST_FULL) && (full_top_reg == op_reg.slab))
            begin
                full_top_next = op_reg.nxt_link;
            end
            if ((op_reg.from_list == LIST_EMPTY) && (empty_top_reg == op_reg.slab))
            begin
                empty_top_next = op_reg.nxt_link;
            end
            // Push at the head of the new list
            if (op_reg.to_list == LIST_PARTIAL)
            begin
                partial_top_next = op_reg.slab;
            end
            if (op_reg.to_list == LIST_FULL)
            begin
                full_top_next = op_reg.slab;
            end
            if (op_reg.to_list == LIST_EMPTY)
            begin
                empty_top_next = op_reg.slab;
            end
            if (op_reg.create)
            begin
                slabs_made_next = slabs_made_reg + slab_id_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            init_addr_reg   <= '0;
            partial_top_reg <= SLAB_NONE;
            full_top_reg    <= SLAB_NONE;
            empty_top_reg   <= SLAB_NONE;
            slabs_made_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            init_addr_reg   <= init_addr_next;
            partial_top_reg <= partial_top_next;
            full_top_reg    <= full_top_next;
            empty_top_reg   <= empty_top_next;
            slabs_made_reg  <= slabs_made_next;
        end
    end

    // Decision and result payload; held through the result cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

    // Slab records; written in the result cycle of every applied command
    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            free_top_reg[op_idx] <= op_reg.top_from_ram ? ram_rdata : op_reg.new_top;
            used_reg[op_idx]     <= op_reg.new_used;

            if (op_reg.from_list != LIST_NONE)
            begin
                if (op_reg.prv_link != SLAB_NONE)
                begin
                    next_reg[op_reg.prv_link[SLAB_IW-1:0]] <= op_reg.nxt_link;
                end
                if (op_reg.nxt_link != SLAB_NONE)
                begin
                    prev_reg[op_reg.nxt_link[SLAB_IW-1:0]] <= op_reg.prv_link;
                end
            end

            if (op_reg.to_list != LIST_NONE)
            begin
                next_reg[op_idx] <= head_to;
                prev_reg[op_idx] <= SLAB_NONE;
                if (head_to != SLAB_NONE)
                begin
                    prev_reg[head_to[SLAB_IW-1:0]] <= op_reg.slab;
                end
            end
            else if (op_reg.from_list != LIST_NONE)
            begin
                next_reg[op_idx] <= SLAB_NONE;
                prev_reg[op_idx] <= SLAB_NONE;
            end
        end
    end

endmodule

[rtl/ssa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_checker
// Port-level timing and result checks for the slab slot allocator.
// ----------------------------------------------------------------------------
module ssa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        status,
    input logic [ssa_pkg::SLAB_IW-1:0] got_slab,
    input logic [ssa_pkg::SLOT_IW-1:0] got_slot
);

    import ssa_pkg::*;

    // Every transfer yields its result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result after command transfer");

    // Results are single-cycle
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // No new transfer is taken while a result is shown
    a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("block not busy during result cycle");

    // A failed allocate reports no slot
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_NO_SLAB)) |-> ((got_slab == '0) && (got_slot == '0)))
        else $error("failed allocate returned a slot");

endmodule

bind slab_slot_allocator_top ssa_checker u_ssa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .got_slab (got_slab),
    .got_slot (got_slot)
);

[tb/slab_alloc_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_alloc_scoreboard_pkg
// Scoreboard for the slab slot allocator: mirrors the slab records and the
// partial/full/empty lists, predicts one outcome per command and checks the
// outcomes that the block returns, oldest first.
// ----------------------------------------------------------------------------
package slab_alloc_scoreboard_pkg;

    import ssa_pkg::*;

    typedef struct packed {
        logic               status;
        logic [SLAB_IW-1:0] slab;
        logic [SLOT_IW-1:0] slot;
    } outcome_t;

    localparam int REPORT_LIMIT = 10;

    class alloc_scoreboard;

        slot_id_t    link_mem  [LINK_DEPTH];
        slot_id_t    free_head [SLABS];
        slot_id_t    in_use    [SLABS];
        slab_id_t    prv       [SLABS];
        slab_id_t    nxt       [SLABS];
        slab_id_t    head_of   [4];        // indexed by list_sel_t
        int unsigned made;
        outcome_t    pending_outcomes [$];
        int unsigned errors;

        function new();
            foreach (link_mem[i]) link_mem[i] = '0;
            for (int i = 0; i < SLABS; i++)
            begin
                free_head[i] = '0;
                in_use[i]    = '0;
                prv[i]       = '0;
                nxt[i]       = '0;
            end
            for (int i = 0; i < 4; i++) head_of[i] = SLAB_NONE;
            made   = 0;
            errors = 0;
        endfunction

        function void unlink(list_sel_t l, slab_id_t s);
            slab_id_t p;
            slab_id_t n;
            p = prv[s];
            n = nxt[s];
            if (p < SLAB_NONE) nxt[p] = n;
            if (n < SLAB_NONE) prv[n] = p;
            if (head_of[l] == s) head_of[l] = n;
            prv[s] = SLAB_NONE;
            nxt[s] = SLAB_NONE;
        endfunction

        function void push_front(list_sel_t l, slab_id_t s);
            nxt[s] = head_of[l];
            prv[s] = SLAB_NONE;
            if (head_of[l] < SLAB_NONE) prv[head_of[l]] = s;
            head_of[l] = s;
        endfunction

        // Advance the mirrored state by one command and return its outcome.
        function outcome_t predict_command(logic cmd, logic [SLAB_IW-1:0] sb,
                                           logic [SLOT_IW-1:0] sl);
            outcome_t r;
            slab_id_t s;
            slot_id_t t;
            r = '0;
            if (cmd == CMD_ALLOC)
            begin
                if (head_of[LIST_PARTIAL] < SLAB_NONE)
                begin
                    s = head_of[LIST_PARTIAL];
                end
                else if (head_of[LIST_EMPTY] < SLAB_NONE)
                begin
                    s = head_of[LIST_EMPTY];
                    unlink(LIST_EMPTY, s);
                    push_front(LIST_PARTIAL, s);
                end
                else if (made < SLABS)
                begin
                    // new slab: free chain runs from the top slot down to 0
                    s = slab_id_t'(made);
                    made++;
                    for (int i = 0; i < SLOTS; i++)
                        link_mem[int'(s) * SLOTS + i] = (i == 0) ? SLOT_NONE
                                                                 : slot_id_t'(i - 1);
                    free_head[s] = slot_id_t'(SLOTS - 1);
                    in_use[s]    = '0;
                    prv[s]       = SLAB_NONE;
                    nxt[s]       = SLAB_NONE;
                    push_front(LIST_PARTIAL, s);
                end
                else
                begin
                    r.status = STAT_NO_SLAB;
                    return r;
                end
                t = free_head[s];
                // an exhausted chain below full count hands out slot 0
                if (t < SLOT_NONE)
                begin
                    r.slot       = t[SLOT_IW-1:0];
                    free_head[s] = link_mem[{s[SLAB_IW-1:0], t[SLOT_IW-1:0]}];
                end
                in_use[s] = in_use[s] + 1'b1;
                if (in_use[s] >= SLOT_NONE)
                begin
                    unlink(LIST_PARTIAL, s);
                    push_front(LIST_FULL, s);
                end
                r.slab = s[SLAB_IW-1:0];
            end
            else
            begin
                // drop frees of unmade slabs and of slabs with nothing in use
                if (sb >= made) return r;
                s = {1'b0, sb};
                if (in_use[s] == '0) return r;
                if (in_use[s] >= SLOT_NONE)
                begin
                    unlink(LIST_FULL, s);
                    push_front(LIST_PARTIAL, s);
                end
                link_mem[{sb, sl}] = free_head[s];
                free_head[s]       = {1'b0, sl};
                in_use[s]          = in_use[s] - 1'b1;
                if (in_use[s] == '0)
                begin
                    unlink(LIST_PARTIAL, s);
                    push_front(LIST_EMPTY, s);
                end
            end
            return r;
        endfunction

        function outcome_t note_command(logic cmd, logic [SLAB_IW-1:0] sb,
                                        logic [SLOT_IW-1:0] sl);
            outcome_t r;
            r = predict_command(cmd, sb, sl);
            pending_outcomes.push_back(r);
            return r;
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: status=%0d slab=%0d slot=%0d",
                             got.status, got.slab, got.slot);
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.status !== want.status || got.slab !== want.slab ||
                got.slot !== want.slot)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             want.status, want.slab, want.slot,
                             got.status, got.slab, got.slot);
            end
        endfunction

    endclass

endpackage

[tb/tb_slab_slot_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slab_slot_allocator_top
// Self-checking bench for the slab slot allocator. A short directed sequence
// walks slab creation, LIFO reuse, the empty list, ignored frees and a double
// free; random phases then churn slots, fill every slab until allocates are
// refused, and drain a whole slab back to the empty list. Every result is
// checked against a scoreboard that mirrors the slab records and lists.
// ----------------------------------------------------------------------------
module tb_slab_slot_allocator_top;

    import ssa_pkg::*;
    import slab_alloc_scoreboard_pkg::*;

    localparam int STALL_LIMIT = 5000;   // cycles without any transfer
    localparam int REFUSALS_WANTED = 12;

    typedef logic [SLAB_IW+SLOT_IW-1:0] slot_ref_t;   // {slab, slot}

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               command   = CMD_ALLOC;
    logic [SLAB_IW-1:0] free_slab = '0;
    logic [SLOT_IW-1:0] free_slot = '0;
    logic               busy;
    logic               done;
    logic               status;
    logic [SLAB_IW-1:0] got_slab;
    logic [SLOT_IW-1:0] got_slot;

    alloc_scoreboard board;
    slot_ref_t       held [$];        // slots currently handed out
    int unsigned     refusals = 0;    // allocates answered with no slab left
    bit              gaps_on  = 1'b1;
    int unsigned     stall_cycles = 0;

    slab_slot_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .free_slab (free_slab),
        .free_slot (free_slot),
        .done      (done),
        .status    (status),
        .got_slab  (got_slab),
        .got_slot  (got_slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check each result in the cycle its strobe is up; the block cannot be
    // stalled, so every strobe is a transfer.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(outcome_t'({status, got_slab, got_slot}));
    end

    // Watchdog: end the run when neither side has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Idle the command side for a random spell: mostly none, sometimes a few
    // cycles, now and then a long gap.
    task automatic sender_gap();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            n = 0;
        else if (roll < 93)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(12, 40);
        if (n != 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Present one command and hold it until the transfer; then note the
    // prediction and keep the list of handed-out slots current.
    task automatic issue(input logic cmd, input logic [SLAB_IW-1:0] sb,
                         input logic [SLOT_IW-1:0] sl);
        outcome_t  r;
        slot_ref_t key;
        int        idx [$];
        start     <= 1'b1;
        command   <= cmd;
        free_slab <= sb;
        free_slot <= sl;
        @(posedge clk);
        while (busy) @(posedge clk);
        r   = board.note_command(cmd, sb, sl);
        key = {sb, sl};
        if (cmd == CMD_ALLOC)
        begin
            if (r.status == STAT_OK)
                held.push_back({r.slab, r.slot});
            else
                refusals++;
        end
        else
        begin
            idx = held.find_first_index(x) with (x == key);
            if (idx.size() != 0) held.delete(idx[0]);
        end
        if (gaps_on) sender_gap();
    endtask

    // One random command: allocate, free a held slot, or free an arbitrary
    // slab/slot pair (unmade slab, idle slab or double free).
    task automatic random_command(input int unsigned alloc_pct,
                                  input int unsigned noise_pct);
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct || held.size() == 0)
        begin
            issue(CMD_ALLOC, SLAB_IW'($urandom), SLOT_IW'($urandom));
        end
        else if (roll < alloc_pct + noise_pct)
        begin
            issue(CMD_FREE, SLAB_IW'($urandom), SLOT_IW'($urandom));
        end
        else
        begin
            pick = $urandom_range(0, held.size() - 1);
            issue(CMD_FREE, held[pick][SLAB_IW+SLOT_IW-1:SLOT_IW],
                  held[pick][SLOT_IW-1:0]);
        end
    endtask

    // Hold off new commands until every predicted result has come back.
    task automatic wait_quiet();
        start <= 1'b0;
        while (board.pending_outcomes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        slot_ref_t          victims [$];
        logic [SLAB_IW-1:0] victim;

        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: slab creation hands out the top slot first, then LIFO
        // reuse, frees into unmade slabs, emptying a slab, a free into an
        // idle slab, reuse from the empty list, and a double free.
        issue(CMD_ALLOC, 4'd15, 6'd63);   // fields ignored on allocate
        issue(CMD_ALLOC, 4'd0, 6'd0);
        issue(CMD_FREE, 4'd0, 6'd62);
        issue(CMD_ALLOC, 4'd0, 6'd0);     // same slot comes back
        issue(CMD_FREE, 4'd15, 6'd63);    // slab not yet made
        issue(CMD_FREE, 4'd1, 6'd0);      // slab not yet made
        issue(CMD_FREE, 4'd0, 6'd63);
        issue(CMD_FREE, 4'd0, 6'd62);     // count hits zero: to the empty list
        issue(CMD_FREE, 4'd0, 6'd62);     // nothing in use: ignored
        issue(CMD_FREE, 4'd0, 6'd0);      // nothing in use: ignored
        issue(CMD_ALLOC, 4'd0, 6'd0);     // taken back from the empty list
        issue(CMD_ALLOC, 4'd0, 6'd0);
        issue(CMD_ALLOC, 4'd0, 6'd0);
        issue(CMD_FREE, 4'd0, 6'd61);
        issue(CMD_FREE, 4'd0, 6'd61);     // double free with slots in use
        issue(CMD_ALLOC, 4'd0, 6'd0);
        issue(CMD_ALLOC, 4'd0, 6'd0);
        issue(CMD_FREE, 4'd0, 6'd61);
        issue(CMD_FREE, 4'd0, 6'd61);
        wait_quiet();

        // Churn: balanced traffic over a few slabs, slabs move between the
        // partial and empty lists, a little noise.
        for (int n = 0; n < 40; n++)
        begin
            if (n % 20 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            random_command(55, 7);
        end
        wait_quiet();

        // Fill: allocate until every slab is made and full and allocates get
        // refused; the odd free lets a full slab drop back to partial.
        for (int n = 0; n < 3000 && refusals < REFUSALS_WANTED; n++)
        begin
            if (n % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            random_command(96, 0);
        end
        wait_quiet();

        // Drain: free one slab completely in random order so it goes full,
        // partial, empty; then reuse it.
        if (held.size() != 0)
        begin
            victim  = held[$urandom_range(0, held.size() - 1)][SLAB_IW+SLOT_IW-1:SLOT_IW];
            victims = held.find(x) with (x[SLAB_IW+SLOT_IW-1:SLOT_IW] == victim);
            victims.shuffle();
            foreach (victims[i])
                issue(CMD_FREE, victims[i][SLAB_IW+SLOT_IW-1:SLOT_IW],
                      victims[i][SLOT_IW-1:0]);
        end
        for (int n = 0; n < 20; n++)
        begin
            if (n % 10 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            random_command(50, 5);
        end

        wait_quiet();
        if (board.errors == 0 && board.pending_outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
